// ===== rtl/ssg_pkg.sv =====
package ssg_pkg;

	localparam int DIMS_DEF   = 16;
	localparam int DIR_BITS   = 32;
	localparam int FRAC_W     = 24;
	localparam int FRAC_SHIFT = 8;
	localparam int MAX_OUT    = 16;

	localparam logic [1:0] OP_LOAD_DIR = 2'd0;
	localparam logic [1:0] OP_LOAD_SCR = 2'd1;
	localparam logic [1:0] OP_JUMP     = 2'd2;
	localparam logic [1:0] OP_NEXT     = 2'd3;

	localparam logic [30:0] POS_MAX = 31'h7fff_ffff;

	typedef struct packed {
		logic cnt_clr;
		logic cnt_inc;
		logic clr;
		logic wr_dir;
		logic wr_scr;
		logic cap_jump;
		logic jump_one;
		logic cap_next;
		logic calc_tz;
		logic walk;
		logic step;
		logic emit;
		logic emit_err;
	} ssg_cmd_t;

	typedef struct packed {
		logic pos_zero;
		logic started;
		logic at_max;
		logic cnt_end_all;
		logic cnt_end_dims;
		logic cnt_end_emit;
		logic can_issue;
		logic pipe_busy;
	} ssg_stat_t;

endpackage

// ===== rtl/ssg_apb.sv =====
module ssg_apb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [4:0]  active_dims
);
	import ssg_pkg::*;

	localparam logic REG_ACTIVE_DIMS = 1'b0;

	logic [4:0] active_dims_q;
	logic       hit;

	assign hit    = (paddr[2] == REG_ACTIVE_DIMS);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_dims_q <= 5'd1;
		end else if (psel && penable && pwrite && pready && hit) begin
			active_dims_q <= pwdata[4:0];
		end
	end

	assign prdata      = hit ? {27'd0, active_dims_q} : 32'd0;
	assign active_dims = active_dims_q;

endmodule

// ===== rtl/ssg_ctrl.sv =====
module ssg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic [1:0]         op,
	output logic               s_tready,
	input  ssg_pkg::ssg_stat_t st,
	output ssg_pkg::ssg_cmd_t  cmd
);
	import ssg_pkg::*;

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_JWALK = 4'd2;
	localparam logic [3:0] ST_NTZ   = 4'd3;
	localparam logic [3:0] ST_NRUN  = 4'd4;
	localparam logic [3:0] ST_DRAIN = 4'd5;
	localparam logic [3:0] ST_EMIT  = 4'd6;
	localparam logic [3:0] ST_ERR   = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_n;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE) && !st.pipe_busy;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		case (state_q)
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (st.cnt_end_all) begin
					cmd.cnt_clr = 1'b1;
					state_n     = ST_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_LOAD_DIR: cmd.wr_dir = 1'b1;
						OP_LOAD_SCR: cmd.wr_scr = 1'b1;
						OP_JUMP: begin
							if (st.pos_zero) begin
								state_n = ST_ERR;
							end else begin
								cmd.cap_jump = 1'b1;
								state_n      = ST_JWALK;
							end
						end
						OP_NEXT: begin
							if (!st.started) begin
								cmd.cap_jump = 1'b1;
								cmd.jump_one = 1'b1;
								state_n      = ST_JWALK;
							end else if (st.at_max) begin
								state_n = ST_ERR;
							end else begin
								cmd.cap_next = 1'b1;
								state_n      = ST_NTZ;
							end
						end
						default: state_n = ST_IDLE;
					endcase
				end
			end
			ST_JWALK: begin
				cmd.walk = 1'b1;
				if (st.cnt_end_all) begin
					cmd.cnt_clr = 1'b1;
					state_n     = ST_DRAIN;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_NTZ: begin
				cmd.calc_tz = 1'b1;
				state_n     = ST_NRUN;
			end
			ST_NRUN: begin
				cmd.step = 1'b1;
				if (st.cnt_end_dims) begin
					cmd.cnt_clr = 1'b1;
					state_n     = ST_DRAIN;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_DRAIN: state_n = ST_EMIT;
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (st.can_issue) begin
					if (st.cnt_end_emit) begin
						cmd.cnt_clr = 1'b1;
						state_n     = ST_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			ST_ERR: begin
				cmd.emit_err = 1'b1;
				if (st.can_issue) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

// ===== rtl/ssg_dpath.sv =====
module ssg_dpath #(
	parameter int DIMS = ssg_pkg::DIMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ssg_pkg::ssg_cmd_t  cmd,
	output ssg_pkg::ssg_stat_t st,
	input  logic [4:0]         active_dims,
	input  logic [3:0]         dim_index,
	input  logic [4:0]         bit_index,
	input  logic [31:0]        load_word,
	input  logic [30:0]        position,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,
	output logic               m_tlast,
	output logic               m_tuser
);
	import ssg_pkg::*;

	localparam int DW      = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int BW      = $clog2(DIR_BITS);
	localparam int AW      = DW + BW;
	localparam int DEPTH   = DIMS * DIR_BITS;
	localparam int LIM     = (DIMS < MAX_OUT) ? DIMS : MAX_OUT;
	localparam logic [AW-1:0] END_ALL  = AW'(DEPTH - 1);
	localparam logic [AW-1:0] END_DIMS = AW'(DIMS - 1);

	function automatic logic [BW-1:0] trail_zeros(input logic [30:0] v);
		logic [30:0]   x;
		logic [BW-1:0] c;
		x = v;
		c = '0;
		if (x[15:0] == 16'd0) begin
			c[4] = 1'b1;
			x    = x >> 16;
		end
		if (x[7:0] == 8'd0) begin
			c[3] = 1'b1;
			x    = x >> 8;
		end
		if (x[3:0] == 4'd0) begin
			c[2] = 1'b1;
			x    = x >> 4;
		end
		if (x[1:0] == 2'd0) begin
			c[1] = 1'b1;
			x    = x >> 2;
		end
		if (!x[0]) begin
			c[0] = 1'b1;
		end
		return c;
	endfunction

	logic [DIR_BITS-1:0] dir_mem [DEPTH];
	logic [31:0]         raw_mem [DIMS];
	logic [31:0]         scr_mem [DIMS];

	logic [AW-1:0]       cnt_q;
	logic [DIR_BITS-1:0] g_q;
	logic [30:0]         idx_q;
	logic [30:0]         np_q;
	logic                started_q;
	logic [BW-1:0]       tz_q;
	logic [31:0]         acc_q;

	logic [31:0]         dir_rd_q;
	logic [31:0]         raw_rd_q;
	logic [31:0]         scr_rd_q;

	logic                walk_s1;
	logic                step_s1;
	logic [AW-1:0]       tag_s1;
	logic                valid_s1;
	logic                err_s1;
	logic                last_s1;
	logic [3:0]          dim_s1;

	logic                out_valid_q;
	logic [3:0]          out_dim_q;
	logic [FRAC_W-1:0]   out_frac_q;
	logic                out_last_q;
	logic                out_err_q;

	logic [4:0]          n_emit;
	logic                dim_ok;
	logic                clr_low;
	logic [DW-1:0]       dim_a;
	logic                out_free;
	logic                can_issue;
	logic                issue;
	logic [31:0]         acc_n;
	logic [31:0]         point;

	logic                dir_we;
	logic [AW-1:0]       dir_wa;
	logic [31:0]         dir_wd;
	logic                dir_re;
	logic [AW-1:0]       dir_ra;
	logic                raw_we;
	logic [DW-1:0]       raw_wa;
	logic [31:0]         raw_wd;
	logic                raw_re;
	logic                scr_we;
	logic [DW-1:0]       scr_wa;
	logic [31:0]         scr_wd;

	always_comb begin
		if (active_dims == 5'd0) begin
			n_emit = 5'd1;
		end else if (active_dims > 5'(LIM)) begin
			n_emit = 5'(LIM);
		end else begin
			n_emit = active_dims;
		end
	end

	assign dim_ok    = 7'(dim_index) < 7'(DIMS);
	assign dim_a     = DW'(dim_index);
	assign clr_low   = cnt_q < AW'(DIMS);
	assign out_free  = !out_valid_q || m_tready;
	assign can_issue = !valid_s1 || out_free;
	assign issue     = (cmd.emit || cmd.emit_err) && can_issue;

	assign st.pos_zero     = (position == 31'd0);
	assign st.started      = started_q;
	assign st.at_max       = (idx_q == POS_MAX);
	assign st.cnt_end_all  = (cnt_q == END_ALL);
	assign st.cnt_end_dims = (cnt_q == END_DIMS);
	assign st.cnt_end_emit = (cnt_q == AW'(n_emit - 5'd1));
	assign st.can_issue    = can_issue;
	assign st.pipe_busy    = valid_s1;

	always_comb begin
		dir_we = 1'b0;
		dir_wa = cnt_q;
		dir_wd = '0;
		if (cmd.clr) begin
			dir_we = 1'b1;
		end else if (cmd.wr_dir && dim_ok) begin
			dir_we = 1'b1;
			dir_wa = {dim_a, bit_index};
			dir_wd = load_word;
		end
	end

	assign dir_re = cmd.walk || cmd.step;
	assign dir_ra = cmd.walk ? cnt_q : {cnt_q[DW-1:0], tz_q};

	always_comb begin
		if (tag_s1[BW-1:0] == '0) begin
			acc_n = g_q[tag_s1[BW-1:0]] ? dir_rd_q : 32'd0;
		end else begin
			acc_n = acc_q ^ (g_q[tag_s1[BW-1:0]] ? dir_rd_q : 32'd0);
		end
	end

	always_comb begin
		raw_we = 1'b0;
		raw_wa = cnt_q[DW-1:0];
		raw_wd = '0;
		if (cmd.clr) begin
			raw_we = clr_low;
		end else if (walk_s1) begin
			raw_we = (tag_s1[BW-1:0] == BW'(DIR_BITS - 1));
			raw_wa = tag_s1[AW-1:BW];
			raw_wd = acc_n;
		end else if (step_s1) begin
			raw_we = 1'b1;
			raw_wa = tag_s1[DW-1:0];
			raw_wd = raw_rd_q ^ dir_rd_q;
		end
	end

	assign raw_re = cmd.step || (issue && cmd.emit);

	always_comb begin
		scr_we = 1'b0;
		scr_wa = cnt_q[DW-1:0];
		scr_wd = '0;
		if (cmd.clr) begin
			scr_we = clr_low;
		end else if (cmd.wr_scr && dim_ok) begin
			scr_we = 1'b1;
			scr_wa = dim_a;
			scr_wd = load_word;
		end
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_wa] <= dir_wd;
		end
		if (dir_re) begin
			dir_rd_q <= dir_mem[dir_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (raw_we) begin
			raw_mem[raw_wa] <= raw_wd;
		end
		if (raw_re) begin
			raw_rd_q <= raw_mem[cnt_q[DW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_mem[scr_wa] <= scr_wd;
		end
		if (issue && cmd.emit) begin
			scr_rd_q <= scr_mem[cnt_q[DW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			idx_q     <= '0;
			started_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (cmd.cap_jump) begin
				idx_q     <= cmd.jump_one ? 31'd1 : position;
				started_q <= 1'b1;
			end else if (cmd.calc_tz) begin
				idx_q <= np_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_jump) begin
			g_q <= cmd.jump_one ? DIR_BITS'(1) : DIR_BITS'(position ^ (position >> 1));
		end
		if (cmd.cap_next) begin
			np_q <= idx_q + 31'd1;
		end
		if (cmd.calc_tz) begin
			tz_q <= trail_zeros(np_q);
		end
		if (walk_s1) begin
			acc_q <= acc_n;
		end
		if (cmd.walk || cmd.step) begin
			tag_s1 <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_s1  <= 1'b0;
			step_s1  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			walk_s1 <= cmd.walk;
			step_s1 <= cmd.step;
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			err_s1  <= cmd.emit_err;
			last_s1 <= cmd.emit_err || st.cnt_end_emit;
			dim_s1  <= cmd.emit_err ? 4'd0 : cnt_q[3:0];
		end
	end

	assign point = raw_rd_q ^ scr_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && out_free) begin
			out_dim_q  <= dim_s1;
			out_frac_q <= err_s1 ? '0 : point[FRAC_SHIFT +: FRAC_W];
			out_last_q <= last_s1;
			out_err_q  <= err_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(32 - FRAC_W - 4)'(0), out_frac_q, out_dim_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

	a_no_walk_and_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(walk_s1 && step_s1))
		else $error("walk and step data returned in the same cycle");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(dim_s1) && $stable(last_s1))
		else $error("coordinate in flight changed while output stalled");

	a_issue_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_err) && !can_issue |-> !cmd.cnt_inc && !cmd.cnt_clr)
		else $error("emission counter moved without an issue slot");

endmodule

// ===== rtl/scrambled_sobol_generator.sv =====
// Channel  Direction  tdata / tuser contents (low bit first)
// s_*      request in tdata: dim_index, bit_index, load_word, position; tuser: op
// m_*      result out tdata: dim_out, fraction, zero pad; tlast: last; tuser: error
// apb      config     register 0 at address 0: active_dims
//
// After reset a clearing pass zeroes the memories; no request is taken then. A next finds the
// trailing-zero bit and steps each dimension, a jump walks every direction word through the
// single read port of the direction memory; then the point streams out at one coordinate per
// cycle while the output is not stalled. A stalled output holds one coordinate in the output
// register and one in flight; a new request is taken once the in-flight coordinate has moved on.
module scrambled_sobol_generator #(
	parameter int DIMS = ssg_pkg::DIMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // dim_index[3:0], bit_index[8:4], load_word[40:9], position[71:41]
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // dim_out[3:0], fraction[27:4], zero[31:28]
	output logic        m_tlast,
	output logic        m_tuser,  // error[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ssg_pkg::*;

	ssg_cmd_t   cmd;
	ssg_stat_t  st;
	logic [4:0] active_dims;

	ssg_apb u_apb (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.active_dims (active_dims)
	);

	ssg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ssg_dpath #(
		.DIMS (DIMS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.active_dims (active_dims),
		.dim_index   (s_tdata[3:0]),
		.bit_index   (s_tdata[8:4]),
		.load_word   (s_tdata[40:9]),
		.position    (s_tdata[71:41]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser)
	);

endmodule

// ===== dv/scrambled_sobol_generator_tb.sv =====
module scrambled_sobol_generator_tb;
	import ssg_pkg::*;

	localparam int          NDIMS     = DIMS_DEF;
	localparam logic [2:0]  REG_ACT   = 3'd0;
	localparam int          SETTLE    = NDIMS * DIR_BITS + 64;
	localparam int          LIMIT     = 20000;
	localparam int          IDLE_PCT  = 13;

	typedef struct packed {
		logic [3:0]  dim;
		logic [23:0] frac;
		logic        last;
		logic        err;
	} coord_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // dim_index[3:0], bit_index[8:4], load_word[40:9], position[71:41]
	logic [1:0]  s_tuser;  // op[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // dim_out[3:0], fraction[27:4], zero[31:28]
	logic        m_tlast;
	logic        m_tuser;  // error[0]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic [31:0] dir_words [NDIMS][DIR_BITS];
	logic [31:0] scr_words [NDIMS];
	logic [31:0] raw_pts [NDIMS];
	logic [30:0] cur_pos;
	logic        started;
	logic [4:0]  act_dims;

	coord_t      coord_q [$];
	coord_t      got_c;
	coord_t      want_c;
	int          fail_cnt = 0;
	int          stall_cnt = 0;
	logic        steady = 1'b0;

	scrambled_sobol_generator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	function automatic int trailing_zeros(input logic [30:0] v);
		int c;
		c = 0;
		while (c < 31 && !v[c])
			c++;
		return c;
	endfunction

	task automatic push_error();
		coord_t c;
		c.dim  = '0;
		c.frac = '0;
		c.last = 1'b1;
		c.err  = 1'b1;
		coord_q.push_back(c);
	endtask

	task automatic push_point();
		coord_t      c;
		int          n;
		logic [31:0] v;
		n = act_dims;
		if (n == 0)
			n = 1;
		if (n > 16)
			n = 16;
		if (n > NDIMS)
			n = NDIMS;
		for (int i = 0; i < n; i++) begin
			v      = raw_pts[i] ^ scr_words[i];
			c.dim  = i[3:0];
			c.frac = v[31:8];
			c.last = (i == n - 1);
			c.err  = 1'b0;
			coord_q.push_back(c);
		end
	endtask

	task automatic gray_jump(input logic [30:0] p);
		logic [31:0] g;
		logic [31:0] acc;
		g = {1'b0, p} ^ ({1'b0, p} >> 1);
		for (int d = 0; d < NDIMS; d++) begin
			acc = '0;
			for (int b = 0; b < DIR_BITS; b++)
				if (g[b])
					acc ^= dir_words[d][b];
			raw_pts[d] = acc;
		end
		cur_pos = p;
		started = 1'b1;
	endtask

	task automatic sobol_predict(input logic [1:0] op, input logic [3:0] dim,
			input logic [4:0] bsel, input logic [31:0] word, input logic [30:0] pos);
		logic [30:0] np;
		int          tz;
		case (op)
			OP_LOAD_DIR: begin
				if (dim < NDIMS)
					dir_words[dim][bsel] = word;
			end
			OP_LOAD_SCR: begin
				if (dim < NDIMS)
					scr_words[dim] = word;
			end
			OP_JUMP: begin
				if (pos == '0) begin
					push_error();
				end else begin
					gray_jump(pos);
					push_point();
				end
			end
			default: begin
				if (!started) begin
					gray_jump(31'd1);
					push_point();
				end else if (cur_pos == POS_MAX) begin
					push_error();
				end else begin
					np = cur_pos + 31'd1;
					tz = trailing_zeros(np);
					if (tz < DIR_BITS)
						for (int d = 0; d < NDIMS; d++)
							raw_pts[d] ^= dir_words[d][tz];
					cur_pos = np;
					push_point();
				end
			end
		endcase
	endtask

	task automatic send_req(input logic [1:0] op, input logic [3:0] dim, input logic [4:0] bsel,
			input logic [31:0] word, input logic [30:0] pos);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pos, word, bsel, dim};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		sobol_predict(op, dim, bsel, word, pos);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (coord_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_active_dims(input logic [4:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ACT;
		pwdata  <= {27'($urandom_range(32'h07ff_ffff)), v};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		act_dims = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[4:0] !== act_dims) begin
			fail_cnt++;
			$display("%0t: active_dims readback expected %h actual %h", $time, act_dims,
				prdata[4:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_c = '{dim: m_tdata[3:0], frac: m_tdata[27:4], last: m_tlast, err: m_tuser};
			if (coord_q.size() == 0) begin
				fail_cnt++;
				$display("%0t: unexpected coordinate, expected none actual %h", $time, got_c);
			end else begin
				want_c = coord_q.pop_front();
				if (got_c !== want_c) begin
					fail_cnt++;
					$display("%0t: coordinate mismatch, ", $time,
						"expected dim %0d frac %h last %b err %b, ",
						want_c.dim, want_c.frac, want_c.last, want_c.err,
						"actual dim %0d frac %h last %b err %b",
						got_c.dim, got_c.frac, got_c.last, got_c.err);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt == LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic test_start_up();
		send_req(OP_NEXT, 4'd0, 5'd0, 32'h0, 31'd0);
		send_req(OP_NEXT, 4'd15, 5'd31, 32'hffff_ffff, POS_MAX);
		drain();
	endtask

	task automatic test_directed_points();
		set_active_dims(5'd16);
		send_req(OP_LOAD_DIR, 4'd0, 5'd0, 32'hffff_ffff, 31'd0);
		send_req(OP_LOAD_DIR, 4'd15, 5'd31, 32'ha5a5_a5a5, POS_MAX);
		send_req(OP_LOAD_DIR, 4'd15, 5'd30, 32'h1234_5678, 31'd0);
		send_req(OP_LOAD_DIR, 4'd3, 5'd0, 32'h0000_00ff, 31'd0);
		send_req(OP_LOAD_DIR, 4'd7, 5'd1, 32'h8000_0100, 31'd0);
		send_req(OP_LOAD_SCR, 4'd0, 5'd0, 32'h8000_0000, 31'd0);
		send_req(OP_LOAD_SCR, 4'd15, 5'd0, 32'hffff_ffff, 31'd0);
		send_req(OP_LOAD_SCR, 4'd9, 5'd0, 32'h0000_00ff, 31'd0);
		send_req(OP_JUMP, 4'd0, 5'd0, 32'h0, 31'd1);
		send_req(OP_NEXT, 4'd0, 5'd0, 32'h0, 31'd0);
		send_req(OP_NEXT, 4'd0, 5'd0, 32'h0, 31'd0);
		send_req(OP_JUMP, 4'd0, 5'd0, 32'h0, POS_MAX);
		send_req(OP_JUMP, 4'd0, 5'd0, 32'h0, 31'h3fff_ffff);
		send_req(OP_NEXT, 4'd0, 5'd0, 32'h0, 31'd0);
		drain();
	endtask

	task automatic test_error_cases();
		send_req(OP_JUMP, 4'd0, 5'd0, 32'h0, 31'd0);
		send_req(OP_JUMP, 4'd0, 5'd0, 32'h0, POS_MAX - 31'd1);
		send_req(OP_NEXT, 4'd0, 5'd0, 32'h0, 31'd0);
		send_req(OP_NEXT, 4'd0, 5'd0, 32'h0, 31'd0);
		send_req(OP_NEXT, 4'd0, 5'd0, 32'h0, 31'd0);
		send_req(OP_JUMP, 4'd0, 5'd0, 32'h0, 31'd0);
		drain();
		set_active_dims(5'd0);
		send_req(OP_JUMP, 4'd0, 5'd0, 32'h0, 31'd5);
		drain();
		set_active_dims(5'd31);
		send_req(OP_JUMP, 4'd0, 5'd0, 32'h0, 31'd6);
		drain();
	endtask

	task automatic test_random_traffic(input logic [4:0] dims_cfg, input int count,
			input logic quiet);
		int          r;
		int          k;
		logic [1:0]  op;
		logic [30:0] pos;
		set_active_dims(dims_cfg);
		steady = quiet;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 25)
				op = OP_LOAD_DIR;
			else if (r < 35)
				op = OP_LOAD_SCR;
			else if (r < 50)
				op = OP_JUMP;
			else
				op = OP_NEXT;
			k = $urandom_range(9);
			if (k == 0)
				pos = '0;
			else if (k < 3)
				pos = POS_MAX - 31'($urandom_range(3));
			else if (k < 6)
				pos = 31'($urandom_range(64));
			else
				pos = 31'($urandom);
			send_req(op, 4'($urandom), 5'($urandom), $urandom, pos);
		end
		drain();
		steady = 1'b0;
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		for (int d = 0; d < NDIMS; d++) begin
			for (int b = 0; b < DIR_BITS; b++)
				dir_words[d][b] = '0;
			scr_words[d] = '0;
			raw_pts[d]   = '0;
		end
		cur_pos  = '0;
		started  = 1'b0;
		act_dims = 5'd1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_start_up();
		test_directed_points();
		test_error_cases();
		test_random_traffic(5'd17, 28, 1'b0);
		test_random_traffic(5'd5, 28, 1'b0);
		test_random_traffic(5'd1, 28, 1'b0);
		test_random_traffic(5'd16, 28, 1'b1);
		test_random_traffic(5'd0, 28, 1'b0);
		test_random_traffic(5'd31, 28, 1'b0);
		test_random_traffic(5'($urandom_range(31)), 28, 1'b0);

		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
